/* hdl/assert_macros.svh */
// Assertion macros used by the checker in hdl/sdiv_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked property, suspended while reset is high.
`define SDIV_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("divider check failed");

// Checked property that also holds across reset.
`define SDIV_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("divider reset check failed");

`endif

/* hdl/sdiv_pkg.sv */
`timescale 1ns / 1ps
package sdiv_pkg;
   localparam int DIVIDEND_W = 64;
   localparam int DIVISOR_W  = 32;
   localparam int QUOTIENT_W = 32;
   localparam int NUM_CELLS  = QUOTIENT_W;
   localparam int REQ_DATA_W = DIVIDEND_W + DIVISOR_W;

   localparam logic [QUOTIENT_W-1:0] POS_MAX = 32'h7FFF_FFFF;
   localparam logic [QUOTIENT_W-1:0] NEG_MIN = 32'h8000_0000;

   typedef struct packed {
      logic                  neg;
      logic [DIVISOR_W-1:0]  rem;
      logic [QUOTIENT_W-1:0] lo;
      logic [DIVISOR_W-1:0]  bmag;
   } sdiv_stage_type;
endpackage

/* hdl/signed_div64_by32_saturating.sv */
// Signed 64-by-32 divider with a 32-bit quotient truncated toward zero; a quotient outside
// the 32-bit range, or a zero divisor, saturates to 0x7FFFFFFF or 0x80000000 by the sign
// of the result. It is a pipeline of 34 registered stages (operand magnitudes, one
// restoring step per quotient bit in 32 cells, sign and saturation), and a new request is
// accepted every cycle unless back-pressure from a stalled output has filled the pipeline.
// Each stage holds its request under back-pressure and empty stages fill up, so requests
// keep entering while a finished result waits at the output.
`timescale 1ns / 1ps
module signed_div64_by32_saturating (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [sdiv_pkg::REQ_DATA_W-1:0]   req_tdata,  // dividend[63:0], divisor[95:64]
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [sdiv_pkg::QUOTIENT_W-1:0]   rsp_tdata   // quotient[31:0]
);
   import sdiv_pkg::*;

   logic [NUM_CELLS:0]          stage_valid;
   logic [NUM_CELLS:0]          stage_ready;
   sdiv_stage_type              stage_data [NUM_CELLS+1];
   logic signed [QUOTIENT_W-1:0] quotient;

   sdiv_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .dividend  (req_tdata[DIVIDEND_W-1:0]),
      .divisor   (req_tdata[REQ_DATA_W-1:DIVIDEND_W]),
      .out_valid (stage_valid[0]),
      .out_ready (stage_ready[0]),
      .out_data  (stage_data[0])
   );

   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      sdiv_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[i]),
         .in_ready  (stage_ready[i]),
         .in_data   (stage_data[i]),
         .out_valid (stage_valid[i+1]),
         .out_ready (stage_ready[i+1]),
         .out_data  (stage_data[i+1])
      );
   end

   sdiv_sat u_sat (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (stage_valid[NUM_CELLS]),
      .in_ready  (stage_ready[NUM_CELLS]),
      .in_data   (stage_data[NUM_CELLS]),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .quotient  (quotient)
   );

   assign rsp_tdata = quotient;
endmodule

/* hdl/sdiv_front.sv */
`timescale 1ns / 1ps
module sdiv_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic signed [sdiv_pkg::DIVIDEND_W-1:0] dividend,
   input  logic signed [sdiv_pkg::DIVISOR_W-1:0]  divisor,
   output logic                              out_valid,
   input  logic                              out_ready,
   output sdiv_pkg::sdiv_stage_type          out_data
);
   import sdiv_pkg::*;

   logic                     valid_ff, valid_in;
   sdiv_stage_type           data_ff, data_in;
   logic                     a_neg, b_neg;
   logic [DIVIDEND_W-1:0]    amag;
   logic                     load;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;

   always_comb begin
      a_neg        = dividend[DIVIDEND_W-1];
      b_neg        = divisor[DIVISOR_W-1];
      amag         = a_neg ? (~dividend + 64'd1) : dividend;
      data_in.neg  = a_neg ^ b_neg;
      data_in.rem  = amag[DIVIDEND_W-1:QUOTIENT_W];
      data_in.lo   = amag[QUOTIENT_W-1:0];
      data_in.bmag = b_neg ? (~divisor + 32'd1) : divisor;
      valid_in     = load || (valid_ff && !out_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
endmodule

/* hdl/sdiv_cell.sv */
`timescale 1ns / 1ps
module sdiv_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  sdiv_pkg::sdiv_stage_type in_data,
   output logic                     out_valid,
   input  logic                     out_ready,
   output sdiv_pkg::sdiv_stage_type out_data
);
   import sdiv_pkg::*;

   logic                   valid_ff, valid_in;
   sdiv_stage_type         data_ff, data_in;
   logic [DIVISOR_W:0]     trial;
   logic [DIVISOR_W+1:0]   diff;
   logic                   ge;
   logic                   load;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;

   // One restoring step: shift in the next dividend bit, subtract if it fits.
   always_comb begin
      trial        = {in_data.rem, in_data.lo[QUOTIENT_W-1]};
      diff         = {1'b0, trial} - {2'b00, in_data.bmag};
      ge           = !diff[DIVISOR_W+1];
      data_in.neg  = in_data.neg;
      data_in.bmag = in_data.bmag;
      data_in.rem  = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      data_in.lo   = {in_data.lo[QUOTIENT_W-2:0], ge};
      valid_in     = load || (valid_ff && !out_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
endmodule

/* hdl/sdiv_sat.sv */
`timescale 1ns / 1ps
module sdiv_sat (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  sdiv_pkg::sdiv_stage_type              in_data,
   output logic                                  out_valid,
   input  logic                                  out_ready,
   output logic signed [sdiv_pkg::QUOTIENT_W-1:0] quotient
);
   import sdiv_pkg::*;

   logic                    valid_ff, valid_in;
   logic [QUOTIENT_W-1:0]   quot_ff, quot_in;
   logic                    load;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;

   // The top quotient bit marks a magnitude of 2^31 or more, a zero divisor included.
   always_comb begin
      if (in_data.lo[QUOTIENT_W-1]) begin
         quot_in = in_data.neg ? NEG_MIN : POS_MAX;
      end else if (in_data.neg) begin
         quot_in = ~in_data.lo + 32'd1;
      end else begin
         quot_in = in_data.lo;
      end
      valid_in = load || (valid_ff && !out_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         quot_ff <= quot_in;
      end
   end

   assign out_valid = valid_ff;
   assign quotient  = quot_ff;
endmodule

/* hdl/sdiv_checker.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sdiv_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [sdiv_pkg::QUOTIENT_W-1:0] rsp_tdata
);
   import sdiv_pkg::*;

   // A stalled result stays in place.
   `SDIV_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))

   // The input side backs up only when the whole pipeline is full and the output is stalled.
   `SDIV_ASSERT(a_full_only, clock, reset, req_tvalid && !req_tready |-> rsp_tvalid && !rsp_tready)

   // An empty output stage always leaves room for a new request.
   `SDIV_ASSERT(a_room, clock, reset, !rsp_tvalid |-> req_tready)

   // Reset empties the output.
   `SDIV_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_tvalid)
endmodule

bind signed_div64_by32_saturating sdiv_checker u_sdiv_checker (.*);

/* bench/sdiv_quotient_checker.sv */
`timescale 1ns / 1ps
module sdiv_quotient_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [sdiv_pkg::REQ_DATA_W-1:0]   req_tdata,  // dividend[63:0], divisor[95:64]
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [sdiv_pkg::QUOTIENT_W-1:0]   rsp_tdata,  // quotient[31:0]
   output int                                outstanding,
   output int                                failures
);
   import sdiv_pkg::*;

   logic [QUOTIENT_W-1:0] expected_quotients[$];
   int                    mismatch_count = 0;

   assign failures = mismatch_count;

   function automatic logic [QUOTIENT_W-1:0] saturating_quotient(
      input logic [DIVIDEND_W-1:0] dividend,
      input logic [DIVISOR_W-1:0]  divisor
   );
      logic                  negative;
      logic [DIVIDEND_W-1:0] dividend_mag;
      logic [DIVISOR_W-1:0]  divisor_mag;
      logic [DIVIDEND_W-1:0] mag_quotient;
      negative     = dividend[DIVIDEND_W-1] ^ divisor[DIVISOR_W-1];
      dividend_mag = dividend[DIVIDEND_W-1] ? -dividend : dividend;
      divisor_mag  = divisor[DIVISOR_W-1] ? -divisor : divisor;
      if (divisor_mag == '0) begin
         return negative ? NEG_MIN : POS_MAX;
      end
      mag_quotient = dividend_mag / {{(DIVIDEND_W-DIVISOR_W){1'b0}}, divisor_mag};
      if (mag_quotient > {{(DIVIDEND_W-QUOTIENT_W){1'b0}}, POS_MAX}) begin
         return negative ? NEG_MIN : POS_MAX;
      end
      return negative ? -mag_quotient[QUOTIENT_W-1:0] : mag_quotient[QUOTIENT_W-1:0];
   endfunction

   task automatic report_mismatch(input string what);
      $display("checker: %0t ns: %s", $realtime, what);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : watch
      logic [QUOTIENT_W-1:0] wanted;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_quotients.size() == 0) begin
               report_mismatch($sformatf("quotient %h with no request pending", rsp_tdata));
            end else begin
               wanted = expected_quotients.pop_front();
               if (rsp_tdata !== wanted) begin
                  report_mismatch($sformatf("quotient %h, expected %h", rsp_tdata, wanted));
               end
            end
         end
         if (req_tvalid && req_tready) begin
            expected_quotients.push_back(saturating_quotient(
               req_tdata[DIVIDEND_W-1:0], req_tdata[REQ_DATA_W-1:DIVIDEND_W]));
         end
      end
      outstanding <= expected_quotients.size();
   end
endmodule

/* bench/signed_div64_by32_saturating_tb.sv */
`timescale 1ns / 1ps
module signed_div64_by32_saturating_tb;
   import sdiv_pkg::*;

   localparam int RANDOM_REQUESTS = 1400;
   localparam int LONG_HOLD       = 300;
   localparam int DRAIN_CYCLES    = 40;

   localparam logic [DIVIDEND_W-1:0] MIN_DIVIDEND = 64'h8000_0000_0000_0000;
   localparam logic [DIVIDEND_W-1:0] MAX_DIVIDEND = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [DIVISOR_W-1:0]  MIN_DIVISOR  = 32'h8000_0000;
   localparam logic [DIVISOR_W-1:0]  MAX_DIVISOR  = 32'h7FFF_FFFF;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;  // dividend[63:0], divisor[95:64]
   logic                  rsp_tready = 1'b0;
   logic                  req_tready;
   logic                  rsp_tvalid;
   logic [QUOTIENT_W-1:0] rsp_tdata;       // quotient[31:0]

   int outstanding;
   int failures;
   int send_idle_pct  = 36;
   int recv_idle_pct  = 50;
   int hold_requested = 0;
   int hold_served    = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   signed_div64_by32_saturating u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   sdiv_quotient_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .outstanding (outstanding),
      .failures    (failures)
   );

   // A long hold keeps the result side stalled so that the pipeline fills and
   // pushes back on the request side.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_requested != hold_served) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_served = hold_requested;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   task automatic send_request(input logic [DIVIDEND_W-1:0] dividend,
                               input logic [DIVISOR_W-1:0] divisor);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {divisor, dividend};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic wait_for_quotients();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   initial begin
      logic [DIVIDEND_W-1:0] dividend;
      logic [DIVIDEND_W-1:0] dividend_mag;
      logic [DIVIDEND_W-1:0] quot_mag;
      logic [DIVIDEND_W-1:0] divisor_mag;
      logic [DIVISOR_W-1:0]  divisor;
      logic                  neg_a;
      logic                  neg_b;
      int                    mode;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      send_request('0, 32'd1);
      send_request('0, '0);
      send_request(64'd5, '0);
      send_request(-64'd5, '0);
      send_request(MIN_DIVIDEND, '0);
      send_request(MAX_DIVIDEND, 32'd1);
      send_request(MIN_DIVIDEND, 32'd1);
      send_request(MIN_DIVIDEND, -32'd1);
      send_request(MIN_DIVIDEND, MIN_DIVISOR);
      send_request(MAX_DIVIDEND, MIN_DIVISOR);
      send_request(-64'h8000_0000, 32'd1);
      send_request(64'h7FFF_FFFF, 32'd1);
      send_request(64'h8000_0000, 32'd1);
      send_request(-64'h8000_0000, -32'd1);
      send_request(64'd7, -32'd2);
      send_request(-64'd7, 32'd2);
      send_request(-64'd7, -32'd2);
      send_request(64'd1, MAX_DIVISOR);
      send_request('1, MAX_DIVISOR);
      send_request('1, MIN_DIVISOR);
      send_request(64'h3FFF_FFFF_0000_0001, MAX_DIVISOR);
      send_request(64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555);
      send_request(64'h5555_5555_5555_5555, 32'hAAAA_AAAA);

      for (int phase = 0; phase < 3; phase++) begin
         wait_for_quotients();
         send_idle_pct = (phase == 0) ? 36 : (phase == 1) ? 50 : 0;
         recv_idle_pct = (phase == 0) ? 50 : (phase == 1) ? 36 : 0;
         if (phase == 2) begin
            hold_requested++;
         end
         for (int i = 0; i < RANDOM_REQUESTS / 3; i++) begin
            mode  = $urandom_range(99);
            neg_a = 1'($urandom_range(1));
            neg_b = 1'($urandom_range(1));
            if (mode < 30) begin
               dividend = {$urandom, $urandom};
               divisor  = $urandom;
            end else if (mode < 90) begin
               // Build the dividend from a chosen quotient so that most results
               // land inside the 32-bit range or right at its edge.
               divisor_mag = 64'($urandom) >> $urandom_range(32, 1);
               if (divisor_mag == '0) begin
                  divisor_mag = 64'd1;
               end
               if (mode < 80) begin
                  quot_mag = 64'($urandom) >> $urandom_range(32, 1);
               end else begin
                  quot_mag = 64'h7FFF_FFFF + 64'($urandom_range(2));
               end
               dividend_mag = quot_mag * divisor_mag + 64'($urandom) % divisor_mag;
               dividend     = neg_a ? -dividend_mag : dividend_mag;
               divisor      = neg_b ? -divisor_mag[DIVISOR_W-1:0]
                                    : divisor_mag[DIVISOR_W-1:0];
            end else begin
               case ($urandom_range(4))
                  0: dividend = MIN_DIVIDEND;
                  1: dividend = MAX_DIVIDEND;
                  2: dividend = '0;
                  3: dividend = '1;
                  default: dividend = {$urandom, $urandom} >> $urandom_range(63, 0);
               endcase
               case ($urandom_range(3))
                  0: divisor = '0;
                  1: divisor = 32'd1;
                  2: divisor = -32'd1;
                  default: divisor = MIN_DIVISOR;
               endcase
            end
            send_request(dividend, divisor);
         end
      end

      wait_for_quotients();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end
endmodule
